FILE: hdl/nsel_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nsel_pkg
// Shared codes and types of the nested shared/exclusive lock table.
// ---------------------------------------------------------------------------
package nsel_pkg;

	// lock kinds, also used as requested lock type and held type
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXCL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SHARED = 2'd2;

	// request actions
	localparam logic [1:0] ACT_ACQUIRE     = 2'd0;
	localparam logic [1:0] ACT_RELEASE     = 2'd1;
	localparam logic [1:0] ACT_RELEASE_ALL = 2'd2;
	localparam logic [1:0] ACT_QUERY       = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NEST_EXCL   = 3'd1;
	localparam logic [2:0] ST_NEST_SHARED = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE    = 3'd3;
	localparam logic [2:0] ST_BAD_KEY     = 3'd4;
	localparam logic [2:0] ST_TIMEOUT     = 3'd5;
	localparam logic [2:0] ST_NOT_LOCKED  = 3'd6;

	localparam int KEY_W     = 32;
	localparam int S_TDATA_W = 48;

	// control and status of one update
	typedef struct packed {
		logic [2:0]        status;
		logic              may_access;
		logic [KIND_W-1:0] held_type;
		logic              key_take;
	} upd_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/nsel_res_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nsel_res_mem
// Per-resource entry memory, one registered read and one write port, plus
// a kind-only clear write used by the post-reset sweep.
// ---------------------------------------------------------------------------
module nsel_res_mem #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 64
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              clr_en,
	input  wire logic [ADDR_W-1:0] clr_addr
);
	import nsel_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end else if (clr_en) begin
			// only the kind field needs a defined value
			mem[clr_addr][KIND_W-1:0] <= KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/nsel_depth_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nsel_depth_mem
// Shared nesting depth memory, one entry per resource and session,
// registered read.
// ---------------------------------------------------------------------------
module nsel_depth_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/nsel_update.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nsel_update
// Lock update logic: takes one request and the entries read for it,
// gives the entries to write back and the owner's standing afterwards.
// ---------------------------------------------------------------------------
module nsel_update #(
	parameter int SES_W = 4,
	parameter int CNT_W = 5,
	parameter int DB    = 16
) (
	input  wire logic [1:0]                  act,
	input  wire logic [nsel_pkg::KIND_W-1:0] typ,
	input  wire logic [SES_W-1:0]            owner,
	input  wire logic                        key_given,
	input  wire logic [nsel_pkg::KEY_W-1:0]  key_value,
	input  wire logic [nsel_pkg::KEY_W-1:0]  key_ctr,
	input  wire logic [nsel_pkg::KIND_W-1:0] kind,
	input  wire logic [SES_W-1:0]            holder,
	input  wire logic [DB-1:0]               enest,
	input  wire logic [nsel_pkg::KEY_W-1:0]  gkey,
	input  wire logic [CNT_W-1:0]            cnt,
	input  wire logic [DB-1:0]               sd,
	output logic      [nsel_pkg::KIND_W-1:0] n_kind,
	output logic      [SES_W-1:0]            n_holder,
	output logic      [DB-1:0]               n_enest,
	output logic      [nsel_pkg::KEY_W-1:0]  n_gkey,
	output logic      [CNT_W-1:0]            n_cnt,
	output logic      [DB-1:0]               n_sd,
	output logic      [nsel_pkg::KEY_W-1:0]  akey,
	output logic      [DB-1:0]               hdepth,
	output nsel_pkg::upd_ctl_t               ctl
);
	import nsel_pkg::*;

	localparam logic [DB-1:0] DMAX = '1;

	logic             rel_all;
	logic             grant;
	logic             sd_nz;
	logic             own_excl;
	logic [CNT_W-1:0] cnt_dec;

	always_comb begin
		n_kind   = kind;
		n_holder = holder;
		n_enest  = enest;
		n_gkey   = gkey;
		n_cnt    = cnt;
		n_sd     = sd;
		akey     = '0;
		ctl      = '0;
		ctl.status = ST_OK;
		rel_all  = (act == ACT_RELEASE_ALL);
		grant    = 1'b0;
		cnt_dec  = cnt;
		sd_nz    = (sd != '0);
		own_excl = (kind == KIND_EXCL) && (holder == owner);

		unique case (act)
			ACT_ACQUIRE: begin
				if (typ != KIND_EXCL && typ != KIND_SHARED) begin
					ctl.status = ST_BAD_TYPE;
				end else if (typ == KIND_EXCL && key_given) begin
					ctl.status = ST_BAD_KEY;
				end else begin
					if (kind == KIND_NONE) begin
						grant = 1'b1;
					end else if (typ == KIND_EXCL) begin
						grant = own_excl;
					end else if (kind != KIND_SHARED) begin
						grant = 1'b0;
					end else begin
						grant = sd_nz || (key_given && gkey == key_value);
					end

					if (!grant) begin
						ctl.status = ST_TIMEOUT;
					end else if (typ == KIND_EXCL) begin
						if (kind == KIND_EXCL) begin
							n_enest    = (enest == DMAX) ? enest : enest + DB'(1);
							ctl.status = ST_NEST_EXCL;
						end else begin
							n_kind   = KIND_EXCL;
							n_holder = owner;
							n_enest  = DB'(1);
						end
					end else if (kind == KIND_SHARED) begin
						// join or nest in the existing group
						if (!sd_nz) begin
							n_cnt = cnt + CNT_W'(1);
						end
						n_sd       = (sd == DMAX) ? sd : sd + DB'(1);
						akey       = gkey;
						ctl.status = sd_nz ? ST_NEST_SHARED : ST_OK;
					end else begin
						// new group takes the next key
						n_kind       = KIND_SHARED;
						n_gkey       = key_ctr;
						ctl.key_take = 1'b1;
						n_cnt        = CNT_W'(1);
						n_sd         = DB'(1);
						akey         = key_ctr;
					end
				end
			end
			ACT_RELEASE, ACT_RELEASE_ALL: begin
				if (own_excl) begin
					if (rel_all || enest <= DB'(1)) begin
						n_enest = '0;
						n_kind  = KIND_NONE;
					end else begin
						n_enest = enest - DB'(1);
					end
				end else if (kind == KIND_SHARED && sd_nz) begin
					n_sd = rel_all ? '0 : sd - DB'(1);
					if (n_sd == '0) begin
						cnt_dec = (cnt != '0) ? cnt - CNT_W'(1) : cnt;
						n_cnt   = cnt_dec;
						if (cnt_dec == '0) begin
							n_kind = KIND_NONE;
						end
					end
				end else if (!rel_all) begin
					ctl.status = ST_NOT_LOCKED;
				end
			end
			ACT_QUERY: begin
			end
		endcase

		// owner's standing after the update
		ctl.may_access = 1'b0;
		ctl.held_type  = KIND_NONE;
		hdepth         = '0;
		if (n_kind == KIND_NONE) begin
			ctl.may_access = 1'b1;
		end else if (n_kind == KIND_EXCL) begin
			if (n_holder == owner) begin
				ctl.may_access = 1'b1;
				ctl.held_type  = KIND_EXCL;
				hdepth         = n_enest;
			end
		end else if (n_kind == KIND_SHARED && n_sd != '0) begin
			ctl.may_access = 1'b1;
			ctl.held_type  = KIND_SHARED;
			hdepth         = n_sd;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/nested_shared_exclusive_lock_table_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nested_shared_exclusive_lock_table_unit
// Per-resource lock table with nesting exclusive and keyed shared locks.
// ---------------------------------------------------------------------------
// usage
// - request words enter on the s_ group: acquire, release, release all on
//   one resource, or query; each request gives exactly one result word on
//   the m_ group describing the owner's standing after the request
// - on accept the resource entry and the shared depth entry are read from
//   their registered memories; the update stage then writes both back
//   while the result enters the output register
// - no new request is accepted before the write-back, because of the
//   read-modify-write of the two memories
// - the output register holds a finished result while the next request is
//   accepted; if the sink still stalls, the update stage waits and s_tready
//   stays low until the output register frees up
// - after reset the block sweeps all NUM_RESOURCES*NUM_SESSIONS entries
//   (256 by default) of the depth memory to zero and marks every resource
//   unlocked, one entry per cycle; s_tready is low during the sweep
// - the shared key counter restarts at zero after reset
// ---------------------------------------------------------------------------
module nested_shared_exclusive_lock_table_unit #(
	parameter int NUM_RESOURCES = 16,
	parameter int NUM_SESSIONS  = 16,
	parameter int DEPTH_BITS    = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// action[1:0], req_kind[3:2], owner[7:4], resource[11:8],
	// key_given[12], key_value[44:13], zero fill above
	input  wire logic [nsel_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// status[2:0], share_key[34:3], may_access[35], held_type[37:36],
	// held_depth[37+DEPTH_BITS:38], zero fill above
	output logic [((38+DEPTH_BITS+7)/8)*8-1:0]    m_tdata
);
	import nsel_pkg::*;

	localparam int SES_W  = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
	localparam int RES_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
	localparam int CNT_W  = $clog2(NUM_SESSIONS + 1);
	localparam int NENT   = NUM_RESOURCES * NUM_SESSIONS;
	localparam int DA_W   = (NENT > 1) ? $clog2(NENT) : 1;
	localparam int DB     = DEPTH_BITS;
	localparam int OUT_W  = 38 + DEPTH_BITS;
	localparam int OUTB_W = ((38 + DEPTH_BITS + 7) / 8) * 8;

	// resource entry layout, kind in the low bits
	localparam int CNT_LO  = KIND_W;
	localparam int HOLD_LO = CNT_LO + CNT_W;
	localparam int NEST_LO = HOLD_LO + SES_W;
	localparam int GKEY_LO = NEST_LO + DB;
	localparam int EW      = GKEY_LO + KEY_W;

	// index folding tables for the 4-bit owner and resource fields
	logic [SES_W-1:0] sess_map [16];
	logic [RES_W-1:0] res_map  [16];
	for (genvar g = 0; g < 16; g++) begin : g_map
		assign sess_map[g] = SES_W'(g % NUM_SESSIONS);
		assign res_map[g]  = RES_W'(g % NUM_RESOURCES);
	end

	// input fields
	logic [1:0]        in_act;
	logic [KIND_W-1:0] in_typ;
	logic [SES_W-1:0]  in_own;
	logic [RES_W-1:0]  in_res;
	logic              in_kg;
	logic [KEY_W-1:0]  in_key;
	logic [DA_W-1:0]   in_daddr;

	assign in_act   = s_tdata[1:0];
	assign in_typ   = s_tdata[3:2];
	assign in_own   = sess_map[s_tdata[7:4]];
	assign in_res   = res_map[s_tdata[11:8]];
	assign in_kg    = s_tdata[12];
	assign in_key   = s_tdata[44:13];
	assign in_daddr = DA_W'(in_res) * DA_W'(NUM_SESSIONS) + DA_W'(in_own);

	// control state
	logic              clr_busy_q;
	logic [DA_W-1:0]   clr_q;
	logic              vld_s1;
	logic [KEY_W-1:0]  kc_q;
	logic              out_valid_q;

	// request held during the update stage
	logic [1:0]        act_s1;
	logic [KIND_W-1:0] typ_s1;
	logic [SES_W-1:0]  own_s1;
	logic [RES_W-1:0]  res_s1;
	logic              kg_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [DA_W-1:0]   daddr_s1;

	// result register fields
	logic [2:0]        status_q;
	logic [KEY_W-1:0]  akey_q;
	logic              may_q;
	logic [KIND_W-1:0] htype_q;
	logic [DB-1:0]     hdepth_q;

	logic accept;
	logic done;
	logic clr_last;
	logic clr_res_en;

	assign s_tready   = !clr_busy_q && !vld_s1;
	assign accept     = s_tvalid && s_tready;
	// the update completes once the output register can take its result
	assign done       = vld_s1 && (!out_valid_q || m_tready);
	assign clr_last   = (clr_q == DA_W'(NENT - 1));
	assign clr_res_en = clr_busy_q && ({1'b0, clr_q} < (DA_W + 1)'(NUM_RESOURCES));

	// memories
	logic [EW-1:0] ent_rd;
	logic [EW-1:0] ent_wr;
	logic [DB-1:0] sd_rd;
	logic [DB-1:0] sd_new;
	logic          dm_wr_en;
	logic [DA_W-1:0] dm_wr_addr;
	logic [DB-1:0] dm_wr_data;

	nsel_res_mem #(
		.DEPTH  (NUM_RESOURCES),
		.ADDR_W (RES_W),
		.DATA_W (EW)
	) u_res_mem (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (in_res),
		.rd_data  (ent_rd),
		.wr_en    (done),
		.wr_addr  (res_s1),
		.wr_data  (ent_wr),
		.clr_en   (clr_res_en),
		.clr_addr (clr_q[RES_W-1:0])
	);

	// the sweep and the write-back never coincide: no request enters during the sweep
	assign dm_wr_en   = done || clr_busy_q;
	assign dm_wr_addr = clr_busy_q ? clr_q : daddr_s1;
	assign dm_wr_data = clr_busy_q ? '0 : sd_new;

	nsel_depth_mem #(
		.DEPTH  (NENT),
		.ADDR_W (DA_W),
		.DATA_W (DB)
	) u_depth_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_daddr),
		.rd_data (sd_rd),
		.wr_en   (dm_wr_en),
		.wr_addr (dm_wr_addr),
		.wr_data (dm_wr_data)
	);

	// update logic
	logic [KIND_W-1:0] n_kind;
	logic [SES_W-1:0]  n_holder;
	logic [DB-1:0]     n_enest;
	logic [KEY_W-1:0]  n_gkey;
	logic [CNT_W-1:0]  n_cnt;
	logic [KEY_W-1:0]  upd_akey;
	logic [DB-1:0]     upd_hdepth;
	upd_ctl_t          upd_ctl;

	nsel_update #(
		.SES_W (SES_W),
		.CNT_W (CNT_W),
		.DB    (DB)
	) u_update (
		.act       (act_s1),
		.typ       (typ_s1),
		.owner     (own_s1),
		.key_given (kg_s1),
		.key_value (key_s1),
		.key_ctr   (kc_q),
		.kind      (ent_rd[KIND_W-1:0]),
		.holder    (ent_rd[HOLD_LO +: SES_W]),
		.enest     (ent_rd[NEST_LO +: DB]),
		.gkey      (ent_rd[GKEY_LO +: KEY_W]),
		.cnt       (ent_rd[CNT_LO +: CNT_W]),
		.sd        (sd_rd),
		.n_kind    (n_kind),
		.n_holder  (n_holder),
		.n_enest   (n_enest),
		.n_gkey    (n_gkey),
		.n_cnt     (n_cnt),
		.n_sd      (sd_new),
		.akey      (upd_akey),
		.hdepth    (upd_hdepth),
		.ctl       (upd_ctl)
	);

	assign ent_wr = {n_gkey, n_enest, n_holder, n_cnt, n_kind};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			kc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + DA_W'(1);
				if (clr_last) begin
					clr_busy_q <= 1'b0;
				end
			end

			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (done) begin
				vld_s1 <= 1'b0;
			end

			// a new shared group consumes one key, wrapping
			if (done && upd_ctl.key_take) begin
				kc_q <= kc_q + KEY_W'(1);
			end

			if (done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= in_act;
			typ_s1   <= in_typ;
			own_s1   <= in_own;
			res_s1   <= in_res;
			kg_s1    <= in_kg;
			key_s1   <= in_key;
			daddr_s1 <= in_daddr;
		end
		if (done) begin
			status_q <= upd_ctl.status;
			akey_q   <= upd_akey;
			may_q    <= upd_ctl.may_access;
			htype_q  <= upd_ctl.held_type;
			hdepth_q <= upd_hdepth;
		end
	end

	// packed result word before the byte fill
	logic [OUT_W-1:0] out_word;

	assign out_word = {hdepth_q, htype_q, may_q, akey_q, status_q};
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUTB_W'(out_word);

`ifndef SYNTHESIS
	// a result appears only right after an update cycle
	a_result_follows_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s1))
		else $error("result appeared without an update");

	// the key counter moves only on a completed update
	a_key_moves_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		(kc_q != $past(kc_q)) |-> $past(done))
		else $error("key counter changed outside an update");

	// a held lock always grants access
	a_held_means_access: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (htype_q != KIND_NONE) |-> may_q)
		else $error("held lock without access");

	// a stalled update keeps its request
	a_update_waits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !done |=> vld_s1 && $stable(daddr_s1))
		else $error("stalled update lost its request");
`endif

endmodule
`default_nettype wire
